// ----- rtl/wmsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wmsp_pkg
// Types, codes and helper functions shared by the module stream parser.
// ----------------------------------------------------------------------------
package wmsp_pkg;

   // parse phase, one-hot
   typedef enum logic [25:0] {
      PH_MAGIC       = 26'h0000001,
      PH_VERSION     = 26'h0000002,
      PH_SEC_ID      = 26'h0000004,
      PH_PAYLOAD     = 26'h0000008,
      PH_COUNT       = 26'h0000010,
      PH_NAME_LEN    = 26'h0000020,
      PH_NAME_BYTES  = 26'h0000040,
      PH_SKIP        = 26'h0000080,
      PH_TYPE_INDEX  = 26'h0000100,
      PH_FORM        = 26'h0000200,
      PH_PARAM_COUNT = 26'h0000400,
      PH_PARAM_TYPE  = 26'h0000800,
      PH_HAS_RESULT  = 26'h0001000,
      PH_RESULT_TYPE = 26'h0002000,
      PH_GLOBAL_TYPE = 26'h0004000,
      PH_MUT         = 26'h0008000,
      PH_EXP_LEN     = 26'h0010000,
      PH_EXP_NAME    = 26'h0020000,
      PH_EXP_KIND    = 26'h0040000,
      PH_EXP_INDEX   = 26'h0080000,
      PH_BODY_SIZE   = 26'h0100000,
      PH_LOCAL_COUNT = 26'h0200000,
      PH_LOCAL_N     = 26'h0400000,
      PH_LOCAL_TYPE  = 26'h0800000,
      PH_CODE_FIRST  = 26'h1000000,
      PH_CODE        = 26'h2000000
   } phase_type;

   // record kinds
   localparam logic [4:0] KIND_MAGIC        = 5'd0;
   localparam logic [4:0] KIND_VERSION      = 5'd1;
   localparam logic [4:0] KIND_SECTION_ID   = 5'd2;
   localparam logic [4:0] KIND_PAYLOAD_LEN  = 5'd3;
   localparam logic [4:0] KIND_ENTRY_COUNT  = 5'd4;
   localparam logic [4:0] KIND_NAME_LEN     = 5'd5;
   localparam logic [4:0] KIND_NAME_BYTE    = 5'd6;
   localparam logic [4:0] KIND_TYPE_INDEX   = 5'd7;
   localparam logic [4:0] KIND_FORM         = 5'd8;
   localparam logic [4:0] KIND_PARAM_COUNT  = 5'd9;
   localparam logic [4:0] KIND_PARAM_TYPE   = 5'd10;
   localparam logic [4:0] KIND_HAS_RESULT   = 5'd11;
   localparam logic [4:0] KIND_RESULT_TYPE  = 5'd12;
   localparam logic [4:0] KIND_GLOBAL_TYPE  = 5'd13;
   localparam logic [4:0] KIND_MUTABILITY   = 5'd14;
   localparam logic [4:0] KIND_EXP_NAME_LEN = 5'd15;
   localparam logic [4:0] KIND_EXP_KIND     = 5'd16;
   localparam logic [4:0] KIND_EXP_INDEX    = 5'd17;
   localparam logic [4:0] KIND_BODY_SIZE    = 5'd18;
   localparam logic [4:0] KIND_LOCAL_COUNT  = 5'd19;
   localparam logic [4:0] KIND_LOCAL_TYPE   = 5'd20;
   localparam logic [4:0] KIND_CODE_LENGTH  = 5'd21;
   localparam logic [4:0] KIND_CODE_BYTE    = 5'd22;

   // status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_SECTION = 2'd1;
   localparam logic [1:0] STATUS_GLOBAL_INIT = 2'd2;

   // section ids
   localparam logic [6:0] SEC_CUSTOM   = 7'd0;
   localparam logic [6:0] SEC_TYPE     = 7'd1;
   localparam logic [6:0] SEC_FUNCTION = 7'd3;
   localparam logic [6:0] SEC_GLOBAL   = 7'd6;
   localparam logic [6:0] SEC_EXPORT   = 7'd7;
   localparam logic [6:0] SEC_CODE     = 7'd10;

   // leb128 limits
   localparam logic [2:0] LEB_MAX_BYTES = 3'd5;
   localparam logic [2:0] LEB_LAST_POS  = 3'd4;

   // parser state
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  word_pos;
      logic [31:0] acc;
      logic [2:0]  leb_cnt;
      logic [3:0]  section;
      logic [31:0] sec_left;
      logic [31:0] entries;
      logic [31:0] items;
      logic [31:0] str_left;
      logic [31:0] body_left;
      logic        halted;
   } state_type;

   // one result item
   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic [1:0]  status;
   } result_type;

   // sign-extend a seven-bit value type
   function automatic logic [31:0] sext7(input logic [7:0] b);
      sext7 = {{25{b[6]}}, b[6:0]};
   endfunction

   // first phase of an entry for a section
   function automatic phase_type entry_phase(input logic [3:0] section);
      case ({3'b000, section})
         SEC_TYPE:     entry_phase = PH_FORM;
         SEC_FUNCTION: entry_phase = PH_TYPE_INDEX;
         SEC_GLOBAL:   entry_phase = PH_GLOBAL_TYPE;
         SEC_EXPORT:   entry_phase = PH_EXP_LEN;
         SEC_CODE:     entry_phase = PH_BODY_SIZE;
         default:      entry_phase = PH_SEC_ID;
      endcase
   endfunction

   // saturating decrement
   function automatic logic [31:0] dec_sat(input logic [31:0] x);
      dec_sat = (x != 32'd0) ? x - 32'd1 : 32'd0;
   endfunction

endpackage

// ----- rtl/wmsp_in_stage.sv -----
// ----------------------------------------------------------------------------
// wmsp_in_stage
// Input register for the byte stream, handing one item at a time to the parser.
// ----------------------------------------------------------------------------
module wmsp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   // free when empty or when the held item moves on
   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ----- rtl/wmsp_parser.sv -----
// ----------------------------------------------------------------------------
// wmsp_parser
// Parser state and the per-byte step logic: word and leb128 assembly,
// section and entry walking, record generation.
// ----------------------------------------------------------------------------
module wmsp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          data_byte,
   output logic                emit,
   output wmsp_pkg::result_type result
);

   wmsp_pkg::state_type state_ff;
   wmsp_pkg::state_type state_in;

   logic [2:0]  leb_pos;
   logic [31:0] leb_part;
   logic [31:0] leb_acc;
   logic [2:0]  leb_cnt_next;
   logic        leb_done;
   logic [31:0] word_acc;
   logic [31:0] entries_dec;
   logic [6:0]  sec_id;
   logic        sec_known;
   logic        sec_phase;
   logic        body_phase;

   // leb128 byte placement, capped at the fifth byte
   always_comb begin
      leb_pos = (state_ff.leb_cnt > wmsp_pkg::LEB_LAST_POS) ? wmsp_pkg::LEB_LAST_POS
                                                             : state_ff.leb_cnt;
      case (leb_pos)
         3'd0:    leb_part = {25'd0, data_byte[6:0]};
         3'd1:    leb_part = {18'd0, data_byte[6:0], 7'd0};
         3'd2:    leb_part = {11'd0, data_byte[6:0], 14'd0};
         3'd3:    leb_part = {4'd0, data_byte[6:0], 21'd0};
         default: leb_part = {data_byte[3:0], 28'd0};
      endcase
      leb_acc      = state_ff.acc | leb_part;
      leb_cnt_next = leb_pos + 3'd1;
      leb_done     = !data_byte[7] || (leb_cnt_next == wmsp_pkg::LEB_MAX_BYTES);
   end

   // header word assembly, little endian
   assign word_acc = state_ff.acc | ({24'd0, data_byte} << {state_ff.word_pos, 3'b000});

   assign entries_dec = wmsp_pkg::dec_sat(state_ff.entries);

   // section id check
   assign sec_id    = data_byte[6:0];
   assign sec_known = (sec_id == wmsp_pkg::SEC_CUSTOM) || (sec_id == wmsp_pkg::SEC_TYPE) ||
                      (sec_id == wmsp_pkg::SEC_FUNCTION) || (sec_id == wmsp_pkg::SEC_GLOBAL) ||
                      (sec_id == wmsp_pkg::SEC_EXPORT) || (sec_id == wmsp_pkg::SEC_CODE);

   // phases that consume section payload and body bytes
   assign sec_phase  = !((state_ff.phase == wmsp_pkg::PH_MAGIC) ||
                         (state_ff.phase == wmsp_pkg::PH_VERSION) ||
                         (state_ff.phase == wmsp_pkg::PH_SEC_ID) ||
                         (state_ff.phase == wmsp_pkg::PH_PAYLOAD));
   assign body_phase = (state_ff.phase == wmsp_pkg::PH_LOCAL_COUNT) ||
                       (state_ff.phase == wmsp_pkg::PH_LOCAL_N) ||
                       (state_ff.phase == wmsp_pkg::PH_LOCAL_TYPE) ||
                       (state_ff.phase == wmsp_pkg::PH_CODE_FIRST) ||
                       (state_ff.phase == wmsp_pkg::PH_CODE);

   // one parse step
   always_comb begin
      state_in      = state_ff;
      emit          = 1'b0;
      result.kind   = wmsp_pkg::KIND_MAGIC;
      result.value  = 32'd0;
      result.status = wmsp_pkg::STATUS_OK;

      if (!state_ff.halted) begin
         if (sec_phase) begin
            state_in.sec_left = wmsp_pkg::dec_sat(state_ff.sec_left);
         end
         if (body_phase) begin
            state_in.body_left = wmsp_pkg::dec_sat(state_ff.body_left);
         end

         // leb phases hold partial values until the last byte
         if (!leb_done) begin
            state_in.acc     = leb_acc;
            state_in.leb_cnt = leb_cnt_next;
         end else begin
            state_in.acc     = 32'd0;
            state_in.leb_cnt = 3'd0;
         end

         case (state_ff.phase)
            wmsp_pkg::PH_MAGIC, wmsp_pkg::PH_VERSION: begin
               state_in.leb_cnt = state_ff.leb_cnt;
               if (state_ff.word_pos != 2'd3) begin
                  state_in.acc      = word_acc;
                  state_in.word_pos = state_ff.word_pos + 2'd1;
               end else begin
                  state_in.acc      = 32'd0;
                  state_in.word_pos = 2'd0;
                  emit              = 1'b1;
                  result.value      = word_acc;
                  if (state_ff.phase == wmsp_pkg::PH_MAGIC) begin
                     state_in.phase = wmsp_pkg::PH_VERSION;
                     result.kind    = wmsp_pkg::KIND_MAGIC;
                  end else begin
                     state_in.phase = wmsp_pkg::PH_SEC_ID;
                     result.kind    = wmsp_pkg::KIND_VERSION;
                  end
               end
            end

            wmsp_pkg::PH_SEC_ID: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_SECTION_ID;
               result.value     = {25'd0, sec_id};
               if (sec_known) begin
                  state_in.section = sec_id[3:0];
                  state_in.phase   = wmsp_pkg::PH_PAYLOAD;
               end else begin
                  state_in.halted = 1'b1;
                  result.status   = wmsp_pkg::STATUS_BAD_SECTION;
               end
            end

            wmsp_pkg::PH_PAYLOAD: begin
               if (leb_done) begin
                  emit              = 1'b1;
                  result.kind       = wmsp_pkg::KIND_PAYLOAD_LEN;
                  result.value      = leb_acc;
                  state_in.sec_left = leb_acc;
                  state_in.phase    = ({3'b000, state_ff.section} == wmsp_pkg::SEC_CUSTOM) ?
                                      wmsp_pkg::PH_NAME_LEN : wmsp_pkg::PH_COUNT;
               end
            end

            wmsp_pkg::PH_COUNT: begin
               if (leb_done) begin
                  emit             = 1'b1;
                  result.kind      = wmsp_pkg::KIND_ENTRY_COUNT;
                  result.value     = leb_acc;
                  state_in.entries = leb_acc;
                  state_in.phase   = (leb_acc == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                     wmsp_pkg::entry_phase(state_ff.section);
               end
            end

            wmsp_pkg::PH_NAME_LEN: begin
               if (leb_done) begin
                  emit              = 1'b1;
                  result.kind       = wmsp_pkg::KIND_NAME_LEN;
                  result.value      = leb_acc;
                  state_in.str_left = leb_acc;
                  if (leb_acc != 32'd0) begin
                     state_in.phase = wmsp_pkg::PH_NAME_BYTES;
                  end else begin
                     state_in.phase = (state_in.sec_left == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                      wmsp_pkg::PH_SKIP;
                  end
               end
            end

            wmsp_pkg::PH_NAME_BYTES: begin
               state_in.acc      = state_ff.acc;
               state_in.leb_cnt  = state_ff.leb_cnt;
               emit              = 1'b1;
               result.kind       = wmsp_pkg::KIND_NAME_BYTE;
               result.value      = {24'd0, data_byte};
               state_in.str_left = wmsp_pkg::dec_sat(state_ff.str_left);
               if (state_in.str_left == 32'd0) begin
                  state_in.phase = (state_in.sec_left == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                   wmsp_pkg::PH_SKIP;
               end
            end

            wmsp_pkg::PH_SKIP: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               if (state_in.sec_left == 32'd0) begin
                  state_in.phase = wmsp_pkg::PH_SEC_ID;
               end
            end

            wmsp_pkg::PH_TYPE_INDEX, wmsp_pkg::PH_EXP_INDEX: begin
               if (leb_done) begin
                  emit             = 1'b1;
                  result.kind      = (state_ff.phase == wmsp_pkg::PH_TYPE_INDEX) ?
                                     wmsp_pkg::KIND_TYPE_INDEX : wmsp_pkg::KIND_EXP_INDEX;
                  result.value     = leb_acc;
                  state_in.entries = entries_dec;
                  state_in.phase   = (entries_dec == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                     wmsp_pkg::entry_phase(state_ff.section);
               end
            end

            wmsp_pkg::PH_FORM: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_FORM;
               result.value     = wmsp_pkg::sext7(data_byte);
               state_in.phase   = wmsp_pkg::PH_PARAM_COUNT;
            end

            wmsp_pkg::PH_PARAM_COUNT: begin
               if (leb_done) begin
                  emit           = 1'b1;
                  result.kind    = wmsp_pkg::KIND_PARAM_COUNT;
                  result.value   = leb_acc;
                  state_in.items = leb_acc;
                  state_in.phase = (leb_acc == 32'd0) ? wmsp_pkg::PH_HAS_RESULT :
                                   wmsp_pkg::PH_PARAM_TYPE;
               end
            end

            wmsp_pkg::PH_PARAM_TYPE: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_PARAM_TYPE;
               result.value     = wmsp_pkg::sext7(data_byte);
               state_in.items   = wmsp_pkg::dec_sat(state_ff.items);
               if (state_in.items == 32'd0) begin
                  state_in.phase = wmsp_pkg::PH_HAS_RESULT;
               end
            end

            wmsp_pkg::PH_HAS_RESULT: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_HAS_RESULT;
               result.value     = {31'd0, (data_byte != 8'd0)};
               if (data_byte != 8'd0) begin
                  state_in.phase = wmsp_pkg::PH_RESULT_TYPE;
               end else begin
                  state_in.entries = entries_dec;
                  state_in.phase   = (entries_dec == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                     wmsp_pkg::entry_phase(state_ff.section);
               end
            end

            wmsp_pkg::PH_RESULT_TYPE: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_RESULT_TYPE;
               result.value     = wmsp_pkg::sext7(data_byte);
               state_in.entries = entries_dec;
               state_in.phase   = (entries_dec == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                  wmsp_pkg::entry_phase(state_ff.section);
            end

            wmsp_pkg::PH_GLOBAL_TYPE: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_GLOBAL_TYPE;
               result.value     = wmsp_pkg::sext7(data_byte);
               state_in.phase   = wmsp_pkg::PH_MUT;
            end

            // initializer expressions are not decoded
            wmsp_pkg::PH_MUT: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_MUTABILITY;
               result.value     = {31'd0, (data_byte != 8'd0)};
               result.status    = wmsp_pkg::STATUS_GLOBAL_INIT;
               state_in.halted  = 1'b1;
            end

            wmsp_pkg::PH_EXP_LEN: begin
               if (leb_done) begin
                  emit              = 1'b1;
                  result.kind       = wmsp_pkg::KIND_EXP_NAME_LEN;
                  result.value      = leb_acc;
                  state_in.str_left = leb_acc;
                  state_in.phase    = (leb_acc == 32'd0) ? wmsp_pkg::PH_EXP_KIND :
                                      wmsp_pkg::PH_EXP_NAME;
               end
            end

            wmsp_pkg::PH_EXP_NAME: begin
               state_in.acc      = state_ff.acc;
               state_in.leb_cnt  = state_ff.leb_cnt;
               emit              = 1'b1;
               result.kind       = wmsp_pkg::KIND_NAME_BYTE;
               result.value      = {24'd0, data_byte};
               state_in.str_left = wmsp_pkg::dec_sat(state_ff.str_left);
               if (state_in.str_left == 32'd0) begin
                  state_in.phase = wmsp_pkg::PH_EXP_KIND;
               end
            end

            wmsp_pkg::PH_EXP_KIND: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_EXP_KIND;
               result.value     = {24'd0, data_byte};
               state_in.phase   = wmsp_pkg::PH_EXP_INDEX;
            end

            wmsp_pkg::PH_BODY_SIZE: begin
               if (leb_done) begin
                  emit               = 1'b1;
                  result.kind        = wmsp_pkg::KIND_BODY_SIZE;
                  result.value       = leb_acc;
                  state_in.body_left = leb_acc;
                  state_in.phase     = wmsp_pkg::PH_LOCAL_COUNT;
               end
            end

            wmsp_pkg::PH_LOCAL_COUNT: begin
               if (leb_done) begin
                  emit           = 1'b1;
                  result.kind    = wmsp_pkg::KIND_LOCAL_COUNT;
                  result.value   = leb_acc;
                  state_in.items = leb_acc;
                  if (leb_acc != 32'd0) begin
                     state_in.phase = wmsp_pkg::PH_LOCAL_N;
                  end else if (state_in.body_left != 32'd0) begin
                     state_in.phase = wmsp_pkg::PH_CODE_FIRST;
                  end else begin
                     state_in.entries = entries_dec;
                     state_in.phase   = (entries_dec == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                        wmsp_pkg::entry_phase(state_ff.section);
                  end
               end
            end

            wmsp_pkg::PH_LOCAL_N: begin
               if (leb_done) begin
                  emit           = 1'b1;
                  result.kind    = wmsp_pkg::KIND_LOCAL_COUNT;
                  result.value   = leb_acc;
                  state_in.phase = wmsp_pkg::PH_LOCAL_TYPE;
               end
            end

            wmsp_pkg::PH_LOCAL_TYPE: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               result.kind      = wmsp_pkg::KIND_LOCAL_TYPE;
               result.value     = wmsp_pkg::sext7(data_byte);
               state_in.items   = wmsp_pkg::dec_sat(state_ff.items);
               if (state_in.items != 32'd0) begin
                  state_in.phase = wmsp_pkg::PH_LOCAL_N;
               end else if (state_in.body_left != 32'd0) begin
                  state_in.phase = wmsp_pkg::PH_CODE_FIRST;
               end else begin
                  state_in.entries = entries_dec;
                  state_in.phase   = (entries_dec == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                     wmsp_pkg::entry_phase(state_ff.section);
               end
            end

            // first code byte reports the code length, itself included
            wmsp_pkg::PH_CODE_FIRST, wmsp_pkg::PH_CODE: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               emit             = 1'b1;
               if (state_ff.phase == wmsp_pkg::PH_CODE_FIRST) begin
                  result.kind  = wmsp_pkg::KIND_CODE_LENGTH;
                  result.value = state_ff.body_left;
               end else begin
                  result.kind  = wmsp_pkg::KIND_CODE_BYTE;
                  result.value = {24'd0, data_byte};
               end
               if (state_in.body_left == 32'd0) begin
                  state_in.entries = entries_dec;
                  state_in.phase   = (entries_dec == 32'd0) ? wmsp_pkg::PH_SEC_ID :
                                     wmsp_pkg::entry_phase(state_ff.section);
               end else begin
                  state_in.phase = wmsp_pkg::PH_CODE;
               end
            end

            default: begin
               state_in.acc     = state_ff.acc;
               state_in.leb_cnt = state_ff.leb_cnt;
               state_in.phase   = wmsp_pkg::PH_SEC_ID;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= wmsp_pkg::PH_MAGIC;
         state_ff.word_pos  <= 2'd0;
         state_ff.acc       <= 32'd0;
         state_ff.leb_cnt   <= 3'd0;
         state_ff.section   <= 4'd0;
         state_ff.sec_left  <= 32'd0;
         state_ff.entries   <= 32'd0;
         state_ff.items     <= 32'd0;
         state_ff.str_left  <= 32'd0;
         state_ff.body_left <= 32'd0;
         state_ff.halted    <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/wmsp_out_stage.sv -----
// ----------------------------------------------------------------------------
// wmsp_out_stage
// Result register holding one record until the receiver takes it.
// ----------------------------------------------------------------------------
module wmsp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  wmsp_pkg::result_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [4:0]           rsp_field_kind,
   output logic [31:0]          rsp_field_value,
   output logic [1:0]           rsp_status
);

   logic                 valid_ff;
   logic                 valid_in;
   wmsp_pkg::result_type data_ff;

   // a new record replaces the one being taken
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_field_kind  = data_ff.kind;
   assign rsp_field_value = data_ff.value;
   assign rsp_status      = data_ff.status;

endmodule

// ----- rtl/wasm_module_stream_parser.sv -----
// ----------------------------------------------------------------------------
// wasm_module_stream_parser
// Streaming parser for a WebAssembly module image, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one module byte per item (req_data_byte), valid/ready.
//   rsp channel: one tagged record per decoded field (kind, value, status).
//   Bytes that complete no field (partial words, leb128 continuation bytes,
//   skipped custom payload) produce no record.
//   Path: a byte is captured in the input register, then parsed, and its
//   record is loaded into the result register and shows on rsp.
//   Throughput: one byte per cycle unless rsp stalls, set by the step logic
//   that updates the phase register and the section, entry and body counters.
//   Stall: while a record waits on rsp, the parser still takes a byte when
//   the receiver frees the result register in the same cycle; otherwise the
//   held byte stays in the input register and req_ready drops.
//   Reset: parser returns to expecting the magic word with all counters
//   cleared and the error flag clear; both registers are emptied.
//   Errors: an unknown section id or a global entry reports its record with
//   nonzero status and then all further bytes are dropped until reset.
// ----------------------------------------------------------------------------
module wasm_module_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_kind,
   output logic [31:0] rsp_field_value,
   output logic [1:0]  rsp_status
);

   logic                 byte_valid;
   logic [7:0]           byte_data;
   logic                 advance;
   logic                 emit;
   wmsp_pkg::result_type result;

   // a held byte moves on when the result register is free
   assign advance = byte_valid && (!rsp_valid || rsp_ready);

   wmsp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .byte_valid    (byte_valid),
      .byte_data     (byte_data)
   );

   wmsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (byte_data),
      .emit      (emit),
      .result    (result)
   );

   wmsp_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && emit),
      .result          (result),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_field_value (rsp_field_value),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- bench/tb_wasm_module_stream_parser.sv -----
// ----------------------------------------------------------------------------
// tb_wasm_module_stream_parser
// Streams a generated module image through the parser byte by byte and checks
// every field record against a behavioral predictor of the parse. The image is
// a short hand-written prefix followed by random well-formed sections (with
// some deliberately short payload and body lengths), and ends with an error
// case and a few bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb_wasm_module_stream_parser;

   // tracks the parse of the accepted bytes and holds the records still due
   class wasm_record_board;
      wmsp_pkg::phase_type  phase;
      logic [1:0]           word_pos;
      logic [31:0]          acc;
      logic [2:0]           leb_n;
      logic [3:0]           section;
      logic [31:0]          sec_left;
      logic [31:0]          entries;
      logic [31:0]          items;
      logic [31:0]          str_left;
      logic [31:0]          body_left;
      bit                   halted;
      wmsp_pkg::result_type due_records[$];
      int unsigned          mismatches;

      function new();
         phase = wmsp_pkg::PH_MAGIC;
         word_pos = '0;
         acc = '0;
         leb_n = '0;
         section = '0;
         sec_left = '0;
         entries = '0;
         items = '0;
         str_left = '0;
         body_left = '0;
         halted = 1'b0;
         mismatches = 0;
      endfunction

      function void add_due(logic [4:0] kind, logic [31:0] value, logic [1:0] status);
         wmsp_pkg::result_type r;
         r.kind = kind;
         r.value = value;
         r.status = status;
         due_records.push_back(r);
      endfunction

      // seven-bit signed value types widen from bit 6
      function logic [31:0] widen_type(logic [7:0] b);
         return b[6] ? {25'h1FFFFFF, b[6:0]} : {25'd0, b[6:0]};
      endfunction

      // one leb128 byte, returns 1 when the value is complete
      function bit leb_step(logic [7:0] b, output logic [31:0] v);
         v = '0;
         if (leb_n > 3'd4) leb_n = 3'd4;
         acc |= {25'd0, b[6:0]} << (7 * leb_n);
         leb_n++;
         if (b[7] && leb_n < 3'd5) return 1'b0;
         v = acc;
         acc = '0;
         leb_n = '0;
         return 1'b1;
      endfunction

      function void begin_entry();
         case ({3'd0, section})
            wmsp_pkg::SEC_TYPE:     phase = wmsp_pkg::PH_FORM;
            wmsp_pkg::SEC_FUNCTION: phase = wmsp_pkg::PH_TYPE_INDEX;
            wmsp_pkg::SEC_GLOBAL:   phase = wmsp_pkg::PH_GLOBAL_TYPE;
            wmsp_pkg::SEC_EXPORT:   phase = wmsp_pkg::PH_EXP_LEN;
            wmsp_pkg::SEC_CODE:     phase = wmsp_pkg::PH_BODY_SIZE;
            default:                phase = wmsp_pkg::PH_SEC_ID;
         endcase
      endfunction

      function void close_entry();
         if (entries != 0) entries--;
         if (entries == 0) phase = wmsp_pkg::PH_SEC_ID;
         else begin_entry();
      endfunction

      function void locals_done();
         if (body_left == 0) close_entry();
         else phase = wmsp_pkg::PH_CODE_FIRST;
      endfunction

      // advance the parse by one accepted byte
      function void take_byte(logic [7:0] b);
         logic [31:0] v;
         logic [31:0] body_was;
         logic [6:0]  id;
         if (halted) return;
         body_was = body_left;
         id = b[6:0];
         if (phase > wmsp_pkg::PH_PAYLOAD && sec_left != 0) sec_left--;
         if (phase >= wmsp_pkg::PH_LOCAL_COUNT && body_left != 0) body_left--;
         case (phase)
            wmsp_pkg::PH_MAGIC, wmsp_pkg::PH_VERSION: begin
               acc |= {24'd0, b} << (8 * word_pos);
               if (word_pos != 2'd3) begin
                  word_pos++;
                  return;
               end
               v = acc;
               acc = '0;
               word_pos = '0;
               if (phase == wmsp_pkg::PH_MAGIC) begin
                  phase = wmsp_pkg::PH_VERSION;
                  add_due(wmsp_pkg::KIND_MAGIC, v, wmsp_pkg::STATUS_OK);
               end else begin
                  phase = wmsp_pkg::PH_SEC_ID;
                  add_due(wmsp_pkg::KIND_VERSION, v, wmsp_pkg::STATUS_OK);
               end
            end
            wmsp_pkg::PH_SEC_ID: begin
               if (id == wmsp_pkg::SEC_CUSTOM || id == wmsp_pkg::SEC_TYPE ||
                   id == wmsp_pkg::SEC_FUNCTION || id == wmsp_pkg::SEC_GLOBAL ||
                   id == wmsp_pkg::SEC_EXPORT || id == wmsp_pkg::SEC_CODE) begin
                  section = id[3:0];
                  phase = wmsp_pkg::PH_PAYLOAD;
                  add_due(wmsp_pkg::KIND_SECTION_ID, {25'd0, id}, wmsp_pkg::STATUS_OK);
               end else begin
                  halted = 1'b1;
                  add_due(wmsp_pkg::KIND_SECTION_ID, {25'd0, id},
                          wmsp_pkg::STATUS_BAD_SECTION);
               end
            end
            wmsp_pkg::PH_PAYLOAD: begin
               if (!leb_step(b, v)) return;
               sec_left = v;
               phase = ({3'd0, section} == wmsp_pkg::SEC_CUSTOM) ? wmsp_pkg::PH_NAME_LEN :
                       wmsp_pkg::PH_COUNT;
               add_due(wmsp_pkg::KIND_PAYLOAD_LEN, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_COUNT: begin
               if (!leb_step(b, v)) return;
               entries = v;
               if (v == 0) phase = wmsp_pkg::PH_SEC_ID;
               else begin_entry();
               add_due(wmsp_pkg::KIND_ENTRY_COUNT, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_NAME_LEN: begin
               if (!leb_step(b, v)) return;
               str_left = v;
               if (v != 0) phase = wmsp_pkg::PH_NAME_BYTES;
               else phase = (sec_left == 0) ? wmsp_pkg::PH_SEC_ID : wmsp_pkg::PH_SKIP;
               add_due(wmsp_pkg::KIND_NAME_LEN, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_NAME_BYTES: begin
               if (str_left != 0) str_left--;
               if (str_left == 0)
                  phase = (sec_left == 0) ? wmsp_pkg::PH_SEC_ID : wmsp_pkg::PH_SKIP;
               add_due(wmsp_pkg::KIND_NAME_BYTE, {24'd0, b}, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_SKIP: begin
               if (sec_left == 0) phase = wmsp_pkg::PH_SEC_ID;
            end
            wmsp_pkg::PH_TYPE_INDEX: begin
               if (!leb_step(b, v)) return;
               close_entry();
               add_due(wmsp_pkg::KIND_TYPE_INDEX, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_FORM: begin
               phase = wmsp_pkg::PH_PARAM_COUNT;
               add_due(wmsp_pkg::KIND_FORM, widen_type(b), wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_PARAM_COUNT: begin
               if (!leb_step(b, v)) return;
               items = v;
               phase = (v == 0) ? wmsp_pkg::PH_HAS_RESULT : wmsp_pkg::PH_PARAM_TYPE;
               add_due(wmsp_pkg::KIND_PARAM_COUNT, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_PARAM_TYPE: begin
               if (items != 0) items--;
               if (items == 0) phase = wmsp_pkg::PH_HAS_RESULT;
               add_due(wmsp_pkg::KIND_PARAM_TYPE, widen_type(b), wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_HAS_RESULT: begin
               if (b != 8'd0) phase = wmsp_pkg::PH_RESULT_TYPE;
               else close_entry();
               add_due(wmsp_pkg::KIND_HAS_RESULT, {31'd0, b != 8'd0}, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_RESULT_TYPE: begin
               close_entry();
               add_due(wmsp_pkg::KIND_RESULT_TYPE, widen_type(b), wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_GLOBAL_TYPE: begin
               phase = wmsp_pkg::PH_MUT;
               add_due(wmsp_pkg::KIND_GLOBAL_TYPE, widen_type(b), wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_MUT: begin
               halted = 1'b1;
               add_due(wmsp_pkg::KIND_MUTABILITY, {31'd0, b != 8'd0},
                       wmsp_pkg::STATUS_GLOBAL_INIT);
            end
            wmsp_pkg::PH_EXP_LEN: begin
               if (!leb_step(b, v)) return;
               str_left = v;
               phase = (v == 0) ? wmsp_pkg::PH_EXP_KIND : wmsp_pkg::PH_EXP_NAME;
               add_due(wmsp_pkg::KIND_EXP_NAME_LEN, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_EXP_NAME: begin
               if (str_left != 0) str_left--;
               if (str_left == 0) phase = wmsp_pkg::PH_EXP_KIND;
               add_due(wmsp_pkg::KIND_NAME_BYTE, {24'd0, b}, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_EXP_KIND: begin
               phase = wmsp_pkg::PH_EXP_INDEX;
               add_due(wmsp_pkg::KIND_EXP_KIND, {24'd0, b}, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_EXP_INDEX: begin
               if (!leb_step(b, v)) return;
               close_entry();
               add_due(wmsp_pkg::KIND_EXP_INDEX, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_BODY_SIZE: begin
               if (!leb_step(b, v)) return;
               body_left = v;
               phase = wmsp_pkg::PH_LOCAL_COUNT;
               add_due(wmsp_pkg::KIND_BODY_SIZE, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_LOCAL_COUNT: begin
               if (!leb_step(b, v)) return;
               items = v;
               if (v == 0) locals_done();
               else phase = wmsp_pkg::PH_LOCAL_N;
               add_due(wmsp_pkg::KIND_LOCAL_COUNT, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_LOCAL_N: begin
               if (!leb_step(b, v)) return;
               phase = wmsp_pkg::PH_LOCAL_TYPE;
               add_due(wmsp_pkg::KIND_LOCAL_COUNT, v, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_LOCAL_TYPE: begin
               if (items != 0) items--;
               if (items == 0) locals_done();
               else phase = wmsp_pkg::PH_LOCAL_N;
               add_due(wmsp_pkg::KIND_LOCAL_TYPE, widen_type(b), wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_CODE_FIRST: begin
               // first code byte reports the code length instead of itself
               if (body_left == 0) close_entry();
               else phase = wmsp_pkg::PH_CODE;
               add_due(wmsp_pkg::KIND_CODE_LENGTH, body_was, wmsp_pkg::STATUS_OK);
            end
            wmsp_pkg::PH_CODE: begin
               if (body_left == 0) close_entry();
               add_due(wmsp_pkg::KIND_CODE_BYTE, {24'd0, b}, wmsp_pkg::STATUS_OK);
            end
            default: phase = wmsp_pkg::PH_SEC_ID;
         endcase
      endfunction

      // compare one delivered record with the oldest one due
      function void check_field(logic [4:0] kind, logic [31:0] value, logic [1:0] status);
         wmsp_pkg::result_type want;
         if (due_records.size() == 0) begin
            $error("unexpected record: field_kind %0d field_value %h status %0d",
                   kind, value, status);
            mismatches++;
            return;
         end
         want = due_records.pop_front();
         if (kind !== want.kind) begin
            $error("field_kind: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("field_value: expected %h, actual %h", want.value, value);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
      endfunction
   endclass

   typedef struct {
      logic [39:0] bytes;
      int unsigned count;
   } leb_code_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_field_kind;
   logic [31:0] rsp_field_value;
   logic [1:0]  rsp_status;

   int unsigned send_idle_pct = 6;
   int unsigned rsp_stall_pct = 49;
   logic [7:0]  image_bytes[$];

   wasm_record_board board = new();

   wasm_module_stream_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_field_value (rsp_field_value),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // free-running limit on the whole run
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.take_byte(req_data_byte);
         if (rsp_valid && rsp_ready)
            board.check_field(rsp_field_kind, rsp_field_value, rsp_status);
      end
   end

   // mostly small values, sometimes the full range
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         3: return $urandom_range(0, 16383);
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   // leb128 with random padding; a fifth byte carries junk in its unused bits
   function automatic leb_code_type encode_leb(logic [31:0] val);
      leb_code_type c;
      int unsigned  n;
      logic [31:0]  rest;
      logic [7:0]   piece;
      n = 1;
      while (n < 5 && (val >> (7 * n)) != 0) n++;
      case ($urandom_range(0, 9))
         0: n = 5;
         1, 2: if (n < 5) n++;
         default: ;
      endcase
      c.count = n;
      c.bytes = '0;
      rest = val;
      for (int i = 0; i < n; i++) begin
         piece = {1'b0, rest[6:0]};
         rest = rest >> 7;
         if (i < n - 1) piece[7] = 1'b1;
         if (i == 4) piece[7:4] = 4'($urandom_range(0, 15));
         c.bytes[8*i +: 8] = piece;
      end
      return c;
   endfunction

   task automatic put_code(leb_code_type c);
      for (int i = 0; i < c.count; i++) image_bytes.push_back(c.bytes[8*i +: 8]);
   endtask

   task automatic put_leb(logic [31:0] val);
      put_code(encode_leb(val));
   endtask

   // append one section with random content; unknown ids stop after the id
   task automatic add_section(logic [6:0] id);
      leb_code_type c;
      int unsigned  n;
      int unsigned  nl;
      int unsigned  hdr;
      int unsigned  pay;
      int unsigned  at;
      int unsigned  len;
      int unsigned  body;
      logic [7:0]   has;
      image_bytes.push_back({1'($urandom_range(0, 1)), id});
      case (id)
         wmsp_pkg::SEC_CUSTOM: begin
            // name, then skipped payload; sometimes the payload is too short
            nl = $urandom_range(0, 6);
            c = encode_leb(nl);
            hdr = c.count + nl;
            if ($urandom_range(0, 5) == 0) pay = $urandom_range(0, hdr);
            else pay = hdr + $urandom_range(0, 5);
            put_leb(pay);
            put_code(c);
            repeat (nl) image_bytes.push_back(8'($urandom_range(0, 255)));
            if (pay > hdr) repeat (pay - hdr) image_bytes.push_back(8'($urandom_range(0, 255)));
         end
         wmsp_pkg::SEC_TYPE: begin
            put_leb(pick_word());
            n = $urandom_range(0, 3);
            put_leb(n);
            repeat (n) begin
               image_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                     8'($urandom_range(0, 255)) : 8'h60);
               nl = $urandom_range(0, 4);
               put_leb(nl);
               repeat (nl) image_bytes.push_back(8'($urandom_range(0, 255)));
               has = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
               image_bytes.push_back(has);
               if (has != 8'd0) image_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
         wmsp_pkg::SEC_FUNCTION: begin
            put_leb(pick_word());
            n = $urandom_range(0, 5);
            put_leb(n);
            repeat (n) put_leb(pick_word());
         end
         wmsp_pkg::SEC_EXPORT: begin
            put_leb(pick_word());
            n = $urandom_range(0, 3);
            put_leb(n);
            repeat (n) begin
               nl = $urandom_range(0, 5);
               put_leb(nl);
               repeat (nl) image_bytes.push_back(8'($urandom_range(0, 255)));
               image_bytes.push_back(8'($urandom_range(0, 255)));
               put_leb(pick_word());
            end
         end
         wmsp_pkg::SEC_CODE: begin
            put_leb(pick_word());
            n = $urandom_range(0, 3);
            put_leb(n);
            repeat (n) begin
               // locals first, body size is slipped in front once known
               at = image_bytes.size();
               nl = $urandom_range(0, 3);
               put_leb(nl);
               repeat (nl) begin
                  put_leb(pick_word());
                  image_bytes.push_back(8'($urandom_range(0, 255)));
               end
               len = image_bytes.size() - at;
               if ($urandom_range(0, 7) == 0) body = $urandom_range(0, len);
               else body = len + $urandom_range(0, 8);
               c = encode_leb(body);
               for (int k = 0; k < c.count; k++) image_bytes.insert(at + k, c.bytes[8*k +: 8]);
               if (body > len)
                  repeat (body - len) image_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
         wmsp_pkg::SEC_GLOBAL: begin
            put_leb(pick_word());
            put_leb($urandom_range(1, 3));
            image_bytes.push_back(8'($urandom_range(0, 255)));
            image_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
         end
         default: ;
      endcase
   endtask

   // stimulus and end of run
   initial begin
      logic [7:0]  lead_in[25];
      logic [6:0]  bad_id;
      int unsigned third;
      // magic, all-ones version, long leb payload, zero count, one short body
      lead_in = '{8'h00, 8'h61, 8'h73, 8'h6D, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h83, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00,
                  8'h01, 8'h00, 8'h00,
                  8'h0A, 8'h04, 8'h01, 8'h02, 8'h00, 8'h0B};
      foreach (lead_in[i]) image_bytes.push_back(lead_in[i]);
      while (image_bytes.size() < 1300) begin
         case ($urandom_range(0, 9))
            0, 1: add_section(wmsp_pkg::SEC_CUSTOM);
            2, 3: add_section(wmsp_pkg::SEC_TYPE);
            4: add_section(wmsp_pkg::SEC_FUNCTION);
            5, 6: add_section(wmsp_pkg::SEC_EXPORT);
            default: add_section(wmsp_pkg::SEC_CODE);
         endcase
      end
      // the run ends in one of the two halting errors
      if ($urandom_range(0, 1) == 0) begin
         add_section(wmsp_pkg::SEC_GLOBAL);
      end else begin
         do bad_id = 7'($urandom_range(0, 127));
         while (bad_id == wmsp_pkg::SEC_CUSTOM || bad_id == wmsp_pkg::SEC_TYPE ||
                bad_id == wmsp_pkg::SEC_FUNCTION || bad_id == wmsp_pkg::SEC_GLOBAL ||
                bad_id == wmsp_pkg::SEC_EXPORT || bad_id == wmsp_pkg::SEC_CODE);
         add_section(bad_id);
      end
      // bytes after the error must be dropped
      repeat (6) image_bytes.push_back(8'($urandom_range(0, 255)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      third = image_bytes.size() / 3;
      foreach (image_bytes[i]) begin
         // change idle pattern, draining all records first
         if (i == third || i == 2 * third) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.due_records.size() != 0) @(posedge clock);
            send_idle_pct = (i == third) ? 49 : 0;
            rsp_stall_pct = (i == third) ? 6 : 0;
         end
         if ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= image_bytes[i];
         do @(posedge clock);
         while (!req_ready);
      end
      req_valid <= 1'b0;

      while (board.due_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.due_records.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
